FILE: rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// shared constants and types for the maximal scoring segments block
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int POS_WIDTH_DEF   = 24;
  localparam int SUM_WIDTH_DEF   = 40;

  localparam int SCORE_WIDTH = 16;
  localparam int IN_DATA_W   = 16;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam logic [0:0] REG_FIRST_POSITION = 1'b0;

  // request handed from the front to the back
  typedef struct packed {
    logic signed [SCORE_WIDTH-1:0] score;
    logic                          last_item;
    logic                          positive;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/mss_front.sv
// ----------------------------------------------------------------------------
// mss_front
// accepts score requests, tags positive scores and queues them for the core
// ----------------------------------------------------------------------------
`default_nettype none

module mss_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [mss_pkg::SCORE_WIDTH-1:0] in_score,
  input  wire logic                            in_last,
  output logic                                 q_valid,
  input  wire logic                            q_pop,
  output mss_pkg::item_t                       q_item
);

  mss_pkg::item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr].score     <= in_score;
      slot[wr_ptr].last_item <= in_last;
      slot[wr_ptr].positive  <= !in_score[mss_pkg::SCORE_WIDTH-1] && (in_score != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mss_core.sv
// ----------------------------------------------------------------------------
// mss_core
// candidate stack, merge walk and flush sequencer with registered output
// ----------------------------------------------------------------------------
`default_nettype none

module mss_core #(
  parameter int STACK_DEPTH = mss_pkg::STACK_DEPTH_DEF,
  parameter int POS_WIDTH   = mss_pkg::POS_WIDTH_DEF,
  parameter int SUM_WIDTH   = mss_pkg::SUM_WIDTH_DEF,
  localparam int OUT_BITS   = 2 * POS_WIDTH + SUM_WIDTH - 1,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  wire mss_pkg::item_t       q_item,
  input  wire logic                 cfg_load,
  input  wire logic [POS_WIDTH-1:0] first_position,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [OUT_W-1:0]          m_tdata,
  output logic                      m_tlast,
  output logic                      m_tuser
);

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LNK_W = $clog2(STACK_DEPTH + 1);
  localparam int SC_W  = SUM_WIDTH - 1;
  localparam int PAD_W = OUT_W - OUT_BITS;
  localparam logic [LNK_W-1:0] DEPTH_L = LNK_W'(STACK_DEPTH);
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [POS_WIDTH-1:0]        start;
    logic [POS_WIDTH-1:0]        stop;
    logic signed [SUM_WIDTH-1:0] sum_before;
    logic signed [SUM_WIDTH-1:0] after;
    logic [LNK_W-1:0]            link;
  } entry_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FL_RD  = 6'b000010,
    ST_FL_EM  = 6'b000100,
    ST_PUSH   = 6'b001000,
    ST_MG_RD  = 6'b010000,
    ST_MG_CMP = 6'b100000
  } state_t;

  entry_t mem [STACK_DEPTH];
  entry_t rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;
  logic             mem_re;
  logic [IDX_W-1:0] mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= mem[mem_ra];
  end

  state_t state, state_next;
  logic [LNK_W-1:0]            count;
  logic signed [SUM_WIDTH-1:0] running_sum;
  logic signed [SUM_WIDTH-1:0] min_sum;
  logic [POS_WIDTH-1:0]        position;
  logic                        overflow_flag;

  // item in flight
  logic [POS_WIDTH-1:0]        it_pos;
  logic signed [SUM_WIDTH-1:0] it_cur;
  logic signed [SUM_WIDTH-1:0] it_nxt;
  logic                        it_last;
  logic                        it_merge;
  logic                        it_flpush;
  logic [LNK_W-1:0]            it_link;
  logic                        fl_two;
  logic                        fl_final;

  // top of the merge walk
  entry_t           top;
  logic [IDX_W-1:0] t_idx;
  logic [LNK_W-1:0] lk;

  // dispatch arithmetic
  logic signed [SUM_WIDTH-1:0] ext;
  logic signed [SUM_WIDTH:0]   wide;
  logic signed [SUM_WIDTH-1:0] nxt;
  logic                        below_min;
  logic                        full;

  assign ext  = SUM_WIDTH'(q_item.score);
  assign wide = {running_sum[SUM_WIDTH-1], running_sum} + {ext[SUM_WIDTH-1], ext};
  always_comb begin
    if (wide[SUM_WIDTH] != wide[SUM_WIDTH-1]) nxt = wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    else                                      nxt = wide[SUM_WIDTH-1:0];
  end
  assign below_min = (running_sum <= min_sum);
  assign full      = (count >= DEPTH_L);

  // segment score from the read entry
  logic signed [SUM_WIDTH:0] diff;
  logic [SC_W-1:0]           seg_score;
  assign diff = {rd_data.after[SUM_WIDTH-1], rd_data.after}
              - {rd_data.sum_before[SUM_WIDTH-1], rd_data.sum_before};
  always_comb begin
    if (diff[SUM_WIDTH])        seg_score = '0;
    else if (diff[SUM_WIDTH-1]) seg_score = '1;
    else                        seg_score = diff[SC_W-1:0];
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  logic [IDX_W-1:0] p_idx;
  assign p_idx = IDX_W'(lk - LNK_W'(1));

  always_comb begin
    state_next = state;
    q_pop  = 1'b0;
    mem_we = 1'b0;
    mem_wa = t_idx;
    mem_wd = top;
    mem_re = 1'b0;
    mem_ra = IDX_W'(count - LNK_W'(1));
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.positive && below_min)   state_next = ST_FL_RD;
          else if (q_item.positive && !full)  state_next = ST_PUSH;
          else if (q_item.last_item)          state_next = ST_FL_RD;
        end
      end
      ST_FL_RD: begin
        if (count == '0) begin
          if (!fl_two && it_flpush)    state_next = ST_PUSH;
          else if (!fl_two && it_last) state_next = ST_FL_RD;
          else                         state_next = ST_IDLE;
        end else begin
          mem_re     = 1'b1;
          state_next = ST_FL_EM;
        end
      end
      ST_FL_EM: begin
        if (out_free) state_next = ST_FL_RD;
      end
      ST_PUSH: begin
        mem_we = 1'b1;
        mem_wa = IDX_W'(count);
        mem_wd = '{start: it_pos, stop: it_pos, sum_before: it_cur, after: it_nxt,
                   link: it_link};
        if (it_merge)     state_next = ST_MG_RD;
        else if (it_last) state_next = ST_FL_RD;
        else              state_next = ST_IDLE;
      end
      ST_MG_RD: begin
        mem_ra = p_idx;
        if (lk == '0 || lk > LNK_W'(t_idx)) begin
          state_next = it_last ? ST_FL_RD : ST_IDLE;
        end else begin
          mem_re     = 1'b1;
          state_next = ST_MG_CMP;
        end
      end
      ST_MG_CMP: begin
        if (rd_data.sum_before < top.sum_before) begin
          mem_we = 1'b1;
          if (rd_data.after < top.after) begin
            mem_wa = p_idx;
            mem_wd = rd_data;
            mem_wd.stop  = it_pos;
            mem_wd.after = top.after;
            state_next = ST_MG_RD;
          end else begin
            mem_wa = t_idx;
            mem_wd = top;
            mem_wd.link = lk;
            state_next = it_last ? ST_FL_RD : ST_IDLE;
          end
        end else begin
          state_next = ST_MG_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      running_sum   <= '0;
      min_sum       <= SUM_MAX;
      position      <= '0;
      overflow_flag <= 1'b0;
      m_tvalid      <= 1'b0;
      fl_two        <= 1'b0;
      fl_final      <= 1'b0;
    end else begin
      state <= state_next;
      // drop valid once taken unless a new segment is loaded this cycle
      if (m_tready && !(state == ST_FL_EM && out_free)) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            it_pos    <= position;
            it_cur    <= running_sum;
            it_nxt    <= nxt;
            it_last   <= q_item.last_item;
            // a candidate pushed after a flush starts with no predecessor
            it_link   <= (q_item.positive && below_min) ? '0 : count;
            it_merge  <= !(q_item.positive && below_min);
            it_flpush <= !(q_item.last_item && full);
            if (q_item.positive && (below_min ? (q_item.last_item && full) : full))
              overflow_flag <= 1'b1;
            if (q_item.positive && below_min) begin
              fl_two   <= 1'b0;
              fl_final <= !(q_item.last_item && !full);
            end else begin
              fl_two   <= 1'b1;
              fl_final <= 1'b1;
            end
            if (q_item.last_item) begin
              running_sum <= '0;
              min_sum     <= SUM_MAX;
              position    <= first_position;
            end else begin
              running_sum <= nxt;
              position    <= position + POS_WIDTH'(1);
              if (q_item.positive && below_min) min_sum <= running_sum;
            end
          end else if (cfg_load) begin
            position <= first_position;
          end
        end
        ST_FL_RD: begin
          if (count == '0 && !fl_two && !it_flpush && it_last) begin
            fl_two   <= 1'b1;
            fl_final <= 1'b1;
          end
        end
        ST_FL_EM: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{PAD_W{1'b0}}, seg_score, rd_data.stop, rd_data.start};
            m_tlast  <= fl_final && (count == LNK_W'(1));
            m_tuser  <= overflow_flag;
            count    <= count - LNK_W'(1);
          end
        end
        ST_PUSH: begin
          top   <= '{start: it_pos, stop: it_pos, sum_before: it_cur, after: it_nxt,
                     link: it_link};
          t_idx <= IDX_W'(count);
          lk    <= it_link;
          count <= count + LNK_W'(1);
          if (!it_merge && it_last) begin
            fl_two   <= 1'b1;
            fl_final <= 1'b1;
          end
        end
        ST_MG_RD: begin
          if ((lk == '0 || lk > LNK_W'(t_idx)) && it_last) begin
            fl_two   <= 1'b1;
            fl_final <= 1'b1;
          end
        end
        ST_MG_CMP: begin
          lk <= rd_data.link;
          if (rd_data.sum_before < top.sum_before) begin
            if (rd_data.after < top.after) begin
              top   <= '{start: rd_data.start, stop: it_pos, sum_before: rd_data.sum_before,
                         after: top.after, link: rd_data.link};
              t_idx <= p_idx;
              count <= lk;
            end else if (it_last) begin
              fl_two   <= 1'b1;
              fl_final <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/maximal_scoring_segments.sv
// ----------------------------------------------------------------------------
// maximal_scoring_segments
// streaming maximal scoring segment finder (stack of candidates with merging)
// ----------------------------------------------------------------------------
// Scores enter on the s_ stream, one per request; tlast marks the final score
// of a sequence and flushes all candidates. Each maximal segment leaves on the
// m_ stream as start, end and score, with tlast on the final segment caused by
// a request and tuser carrying the sticky stack-overflow flag. A two-entry
// queue separates the input side from the stack engine. Per request the engine
// dispatches, pushes a positive score, walks the merge links reading each one,
// and flushes by reading and emitting each segment until the stack is seen
// empty, all through one stack memory read port. A zero or negative score that
// is not last needs only the dispatch; the longest request is a full merge walk
// followed by a full flush, plus any output stall. The engine takes the next
// request from the queue only once it is idle again. The stack is a memory with
// no clearing pass: entries above the stack count are never read. The user is
// to write register first_position (address 0) over APB only while the block is
// idle, which it does not enforce; a write also reloads the current position.
// ----------------------------------------------------------------------------
`default_nettype none

module maximal_scoring_segments #(
  parameter int STACK_DEPTH = mss_pkg::STACK_DEPTH_DEF,
  parameter int POS_WIDTH   = mss_pkg::POS_WIDTH_DEF,
  parameter int SUM_WIDTH   = mss_pkg::SUM_WIDTH_DEF,
  localparam int OUT_BITS   = 2 * POS_WIDTH + SUM_WIDTH - 1,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // apb configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mss_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // score stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [mss_pkg::IN_DATA_W-1:0]  s_tdata,  // score
  input  wire logic                           s_tlast,  // last_item
  // segment stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [OUT_W-1:0]                    m_tdata,  // seg_start, seg_end, seg_score
  output logic                                m_tlast,  // last_of_run
  output logic                                m_tuser   // overflowed
);

  logic [POS_WIDTH-1:0] first_position;
  logic [POS_WIDTH-1:0] first_position_next;
  logic                 cfg_load;
  logic                 q_valid;
  logic                 q_pop;
  mss_pkg::item_t       q_item;

  // register write completes on the access cycle
  assign pready   = 1'b1;
  assign cfg_load = psel && penable && pwrite && pready
                 && (paddr[2] == mss_pkg::REG_FIRST_POSITION);
  assign first_position_next = cfg_load ? pwdata[POS_WIDTH-1:0] : first_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_position <= '0;
    end else begin
      first_position <= first_position_next;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mss_pkg::REG_FIRST_POSITION) prdata[POS_WIDTH-1:0] = first_position;
  end

  // front: accept and tag requests
  mss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_score (s_tdata),
    .in_last  (s_tlast),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // back: candidate stack and segment output
  mss_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .POS_WIDTH   (POS_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_item         (q_item),
    .cfg_load       (cfg_load),
    .first_position (first_position_next),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .m_tuser        (m_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/mss_checker.sv
// ----------------------------------------------------------------------------
// mss_checker
// port-level checks for the maximal scoring segments block
// ----------------------------------------------------------------------------
`default_nettype none

module mss_checker #(
  parameter int OUT_W = 88
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata,
  input wire logic             m_tlast,
  input wire logic             m_tuser
);

  logic seen_ovf;

  always_ff @(posedge clk) begin
    if (rst) seen_ovf <= 1'b0;
    else if (m_tvalid && m_tready && m_tuser) seen_ovf <= 1'b1;
  end

  // stalled segment holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("segment changed while stalled");

  // overflow flag is sticky across segments
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seen_ovf |-> m_tuser)
    else $error("overflow flag dropped");

  // reset empties the output stage
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("segment valid after reset");

endmodule

bind maximal_scoring_segments mss_checker #(.OUT_W(OUT_W)) u_mss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the maximal scoring segments block
// ----------------------------------------------------------------------------
// Score sequences are driven on the slave stream in random bursts. A local
// segment finder with its own candidate stack predicts every segment, and the
// monitor compares each accepted segment with the oldest prediction. The
// first_position register is rewritten over APB between phases while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = mss_pkg::STACK_DEPTH_DEF;
  localparam int PW = mss_pkg::POS_WIDTH_DEF;
  localparam int SW = mss_pkg::SUM_WIDTH_DEF;
  localparam int OUT_W = (((2 * PW + SW - 1) + 7) / 8) * 8;
  localparam longint SMAX = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [PW-1:0]   start_pos;
    logic [PW-1:0]   end_pos;
    logic [SW-2:0]   total;
    logic            last_seg;
    logic            ovf;
  } segment_t;

  typedef struct packed {
    logic signed [15:0] score;
    logic               last_item;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [mss_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [mss_pkg::IN_DATA_W-1:0] s_tdata = '0;   // score
  logic s_tlast = 1'b0;                 // last_item
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;            // seg_start, seg_end, seg_score
  logic m_tlast;                        // last_of_run
  logic m_tuser;                        // overflowed

  maximal_scoring_segments i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // segment finder state
  logic [PW-1:0] c_start [DEPTH];
  logic [PW-1:0] c_end [DEPTH];
  longint        c_before [DEPTH];
  longint        c_after [DEPTH];
  int            c_link [DEPTH];
  int            depth_used;
  longint        run_sum;
  longint        low_sum;
  logic [PW-1:0] cur_pos;
  logic [PW-1:0] base_pos;
  logic          ovf_sticky;

  request_t pending_scores[$];
  segment_t expected_segments[$];
  int       failures = 0;
  int       idle_cycles = 0;
  logic     feeding = 1'b0;   // driver may start requests
  logic     in_taken = 1'b0;  // request accepted at the last rising edge

  function automatic longint sat_sum(longint a, longint x);
    if (x > 0 && a > SMAX - x) return SMAX;
    if (x < 0 && a < SMIN - x) return SMIN;
    return a + x;
  endfunction

  function automatic void reset_finder();
    depth_used = 0;
    run_sum = 0;
    low_sum = SMAX;
    base_pos = '0;
    cur_pos = '0;
    ovf_sticky = 1'b0;
  endfunction

  // pop every candidate, top first
  function automatic void flush_segments(ref segment_t found[$]);
    segment_t s;
    longint d;
    while (depth_used > 0) begin
      depth_used--;
      d = c_after[depth_used] - c_before[depth_used];
      if (d < 0) d = 0;
      if (d > SMAX) d = SMAX;
      s.start_pos = c_start[depth_used];
      s.end_pos = c_end[depth_used];
      s.total = d[SW-2:0];
      s.last_seg = 1'b0;
      s.ovf = 1'b0;
      found.push_back(s);
    end
  endfunction

  function automatic void push_candidate(logic [PW-1:0] p, longint b, longint a, int lk);
    c_start[depth_used] = p;
    c_end[depth_used] = p;
    c_before[depth_used] = b;
    c_after[depth_used] = a;
    c_link[depth_used] = lk;
    depth_used++;
  endfunction

  // merge the new top leftward along the links while it dominates
  function automatic void merge_candidates(logic [PW-1:0] p);
    int t, lk, q;
    t = depth_used - 1;
    lk = c_link[t];
    while (lk != 0 && lk <= t) begin
      q = lk - 1;
      if (c_before[q] < c_before[t]) begin
        if (c_after[q] < c_after[t]) begin
          c_end[q] = p;
          c_after[q] = c_after[t];
          t = q;
          depth_used = q + 1;
        end else begin
          c_link[t] = q + 1;
          return;
        end
      end
      lk = c_link[q];
    end
  endfunction

  function automatic void predict_segments(request_t r);
    segment_t found[$];
    longint x, nxt;
    logic full;
    x = longint'(r.score);
    nxt = sat_sum(run_sum, x);
    if (x > 0) begin
      if (run_sum <= low_sum) begin
        full = depth_used >= DEPTH;
        flush_segments(found);
        if (r.last_item && full) ovf_sticky = 1'b1;
        else begin
          push_candidate(cur_pos, run_sum, nxt, 0);
          low_sum = run_sum;
        end
      end else if (depth_used >= DEPTH) begin
        ovf_sticky = 1'b1;
      end else begin
        push_candidate(cur_pos, run_sum, nxt, depth_used);
        merge_candidates(cur_pos);
      end
    end
    run_sum = nxt;
    cur_pos = cur_pos + 1'b1;
    if (r.last_item) begin
      flush_segments(found);
      run_sum = 0;
      low_sum = SMAX;
      cur_pos = base_pos;
    end
    foreach (found[k]) begin
      found[k].ovf = ovf_sticky;
      if (k == found.size() - 1) found[k].last_seg = 1'b1;
      expected_segments.push_back(found[k]);
    end
  endfunction

  always @(posedge clk) in_taken <= s_tvalid && s_tready;

  // driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_taken) begin
        // hold the request
      end else if (feeding && pending_scores.size() > 0 && gap_left == 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_scores[0].score;
        s_tlast <= pending_scores[0].last_item;
        void'(pending_scores.pop_front());
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
        end else begin
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    m_tready <= (stall_phase % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  // monitor: predict on accepted requests, check accepted segments
  always @(posedge clk) begin
    segment_t got, exp_seg;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_segments('{score: s_tdata, last_item: s_tlast});
      if (m_tvalid && m_tready) begin
        got.start_pos = m_tdata[PW-1:0];
        got.end_pos = m_tdata[2*PW-1:PW];
        got.total = m_tdata[2*PW+SW-2:2*PW];
        got.last_seg = m_tlast;
        got.ovf = m_tuser;
        if (expected_segments.size() == 0) begin
          $error("unexpected segment start=%0d end=%0d", got.start_pos, got.end_pos);
          failures++;
        end else begin
          exp_seg = expected_segments.pop_front();
          if (got.start_pos !== exp_seg.start_pos) begin
            $error("seg_start exp %0d got %0d", exp_seg.start_pos, got.start_pos);
            failures++;
          end
          if (got.end_pos !== exp_seg.end_pos) begin
            $error("seg_end exp %0d got %0d", exp_seg.end_pos, got.end_pos);
            failures++;
          end
          if (got.total !== exp_seg.total) begin
            $error("seg_score exp %0d got %0d", exp_seg.total, got.total);
            failures++;
          end
          if (got.last_seg !== exp_seg.last_seg) begin
            $error("last_of_run exp %0d got %0d", exp_seg.last_seg, got.last_seg);
            failures++;
          end
          if (got.ovf !== exp_seg.ovf) begin
            $error("overflowed exp %0d got %0d", exp_seg.ovf, got.ovf);
            failures++;
          end
        end
      end
      // watchdog on cycles with no transfer
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || expected_segments.size() == 0
          && !s_tvalid)
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("maximal_scoring_segments verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_scores.size() > 0 || s_tvalid || expected_segments.size() > 0)
      @(posedge clk);
    // requests with no segment may still be queued or in the engine
    repeat (4 * DEPTH + 20) @(posedge clk);
  endtask

  task automatic write_first_position(logic [PW-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {mss_pkg::REG_FIRST_POSITION, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    base_pos = value;
    cur_pos = value;
  endtask

  function automatic void add_score(int s, bit last = 1'b0);
    pending_scores.push_back('{score: 16'(s), last_item: last});
  endfunction

  // well-formed sequences of mixed scores, ending with last_item
  task automatic add_sequence(int len, int spread);
    for (int i = 0; i < len; i++) begin
      int s;
      case ($urandom_range(0, 9))
        0: s = 32767;
        1: s = -32768;
        2: s = 0;
        default: s = int'($urandom_range(0, 2 * spread)) - spread;
      endcase
      add_score(s, i == len - 1);
    end
  endtask

  task automatic run_phase();
    feeding = 1'b1;
    wait_drained();
    feeding = 1'b0;
  endtask

  initial begin
    reset_finder();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, zero score, merging
    add_score(32767); add_score(-32768); add_score(0); add_score(5);
    add_score(-3); add_score(7); add_score(-1); add_score(4, 1'b1);
    add_score(-32768, 1'b1);
    add_score(0, 1'b1);
    add_score(32767, 1'b1);
    add_score(3); add_score(-1); add_score(2); add_score(-5); add_score(6, 1'b1);
    run_phase();

    write_first_position(24'hFFFFFE);   // position wrap
    add_score(1); add_score(2); add_score(-4); add_score(3); add_score(9, 1'b1);
    run_phase();

    // long runs of extreme scores
    write_first_position(24'hABCDEF);
    for (int i = 0; i < 20; i++) add_score(32767, i == 19);
    for (int i = 0; i < 10; i++) add_score(-32768);
    add_score(1, 1'b1);
    run_phase();

    // overflow: equal starting sums above the low mark never merge
    write_first_position(24'h000100);
    add_score(-30000); add_score(20000); add_score(-19000);
    for (int i = 0; i < DEPTH + 4; i++) begin
      add_score(-1);
      add_score(1);
    end
    add_score(-1, 1'b1);
    run_phase();
    // full stack with last_item on a flushing positive score
    add_score(-30000); add_score(20000); add_score(-19000);
    for (int i = 0; i < DEPTH - 1; i++) begin
      add_score(-1);
      add_score(1);
    end
    add_score(-30000); add_score(50, 1'b1);
    run_phase();

    // random phases with register rewrites
    for (int ph = 0; ph < 6; ph++) begin
      write_first_position(ph == 0 ? 24'h0 : ph == 5 ? 24'hFFFFFF : 24'($urandom));
      while (pending_scores.size() < 15) begin
        if ($urandom_range(0, 5) == 0) add_score(int'($urandom_range(0, 65535)) - 32768);
        else add_sequence($urandom_range(1, 20), $urandom_range(0, 3) == 0 ? 32767 : 50);
      end
      run_phase();
    end

    if (failures == 0) begin
      $display("maximal_scoring_segments verification clean");
    end else begin
      $display("maximal_scoring_segments verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
